### design/scr_pkg.sv
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and constants for the slot cache replacement core.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int unsigned TagW    = 32;
  localparam int unsigned MetricW = 48;
  localparam int unsigned TokW    = 16;
  localparam logic [MetricW-1:0] MetricMax = {MetricW{1'b1}};

  typedef enum logic [1:0] {
    POL_TOKEN = 2'd0,
    POL_LFU   = 2'd1,
    POL_LRU   = 2'd2,
    POL_FIFO  = 2'd3
  } policy_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_e;

endpackage

### design/slot_cache_replacement_core.sv
// ----------------------------------------------------------------------------
// slot_cache_replacement_core
// Slot pool with tag lookup and token/LFU/LRU/FIFO victim selection.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals                               Handshake
// command   in         kind_i node_tag_i tokens_i            start_i & !busy_o
// result    out        hit_o slot_index_o evicted_o          done_o, one cycle
//                      evicted_tag_o status_o
// config    in         cfg_data_i                            cfg_we_i
//
// busy stays high for the whole transaction, through three phases: ST_SCAN
// issues one memory read per slot, ST_LAST drains the read pipeline, and the
// ST_WRITE write-back updates the slot. done is registered and follows in the
// next cycle, and a new transaction can be taken in the done cycle. The single
// read port of the slot memory is why the scan reads one slot at a time.
// Valid bits sit in flip-flops cleared by reset. The receiver cannot stall.
// ----------------------------------------------------------------------------
module slot_cache_replacement_core
  import scr_pkg::*;
#(
  parameter int unsigned SLOTS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic                kind_i,
  input  logic [TagW-1:0]     node_tag_i,
  input  logic [TokW-1:0]     tokens_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_data_i,
  output logic                done_o,
  output logic                hit_o,
  output logic [5:0]          slot_index_o,
  output logic                evicted_o,
  output logic [TagW-1:0]     evicted_tag_o,
  output logic                status_o
);
  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam int unsigned MemW = TagW + MetricW;

  state_e state_q, state_d;
  logic [1:0]          policy_q;
  logic [SLOTS-1:0]    valid_q;
  logic [MetricW-1:0]  clock_q;
  logic                kind_q;
  logic [TagW-1:0]     tag_q;
  logic [TokW-1:0]     tok_q;
  logic [IdxW-1:0]     raddr_q;   // read address being issued
  logic [IdxW-1:0]     cidx_q;    // index of data arriving this cycle
  // scan results
  logic                found_q, free_q;
  logic [IdxW-1:0]     fidx_q, freeidx_q, midx_q;
  logic [MetricW-1:0]  fmet_q, mmet_q;
  logic [TagW-1:0]     mtag_q;
  logic                first_q;

  logic [MemW-1:0] rdata;
  logic [TagW-1:0]    rtag;
  logic [MetricW-1:0] rmet;
  assign rtag = rdata[MemW-1:MetricW];
  assign rmet = rdata[MetricW-1:0];

  // write port
  logic            we;
  logic [IdxW-1:0] waddr;
  logic [MemW-1:0] wdata;

  scr_ram #(.Width(MemW), .Depth(SLOTS)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr_q),
    .rdata_o(rdata)
  );

  logic scanning;
  assign scanning = (state_q == ST_SCAN) || (state_q == ST_LAST);

  // write-back decision, computed in ST_WRITE
  logic [MetricW-1:0] clk_next, hit_met, sum;
  logic [MetricW:0]   sum_w;
  logic [IdxW-1:0]    target;
  always_comb begin
    clk_next = (clock_q == MetricMax) ? clock_q : clock_q + 1'b1;
    sum_w = {1'b0, fmet_q} +
            ((policy_q == POL_TOKEN) ? {{(MetricW+1-TokW){1'b0}}, tok_q}
                                     : {{MetricW{1'b0}}, 1'b1});
    sum = sum_w[MetricW] ? MetricMax : sum_w[MetricW-1:0];
    case (policy_q)
      POL_TOKEN, POL_LFU: hit_met = sum;
      POL_LRU:            hit_met = clk_next;
      default:            hit_met = fmet_q;
    endcase
    target = free_q ? freeidx_q : midx_q;
    we = 1'b0;
    waddr = fidx_q;
    wdata = {tag_q, hit_met};
    if (state_q == ST_WRITE && !kind_q) begin
      we = 1'b1;
      if (!found_q) begin
        waddr = target;
        wdata = {tag_q, (policy_q inside {POL_TOKEN, POL_LFU})
                        ? {{(MetricW-1){1'b0}}, 1'b1} : clk_next};
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ST_SCAN;
      ST_SCAN:  if (raddr_q == IdxW'(SLOTS-1)) state_d = ST_LAST;
      ST_LAST:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      policy_q <= POL_TOKEN;
      valid_q  <= '0;
      clock_q  <= '0;
      done_o   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= 1'b0;
      if (cfg_we_i) policy_q <= cfg_data_i;
      if (state_q == ST_WRITE) begin
        done_o <= 1'b1;
        if (kind_q) begin
          if (found_q) valid_q[fidx_q] <= 1'b0;
        end else begin
          clock_q <= clk_next;
          if (!found_q) valid_q[target] <= 1'b1;
        end
      end
    end
  end

  // scan datapath; payload registers carry no reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      kind_q  <= kind_i;
      tag_q   <= node_tag_i;
      tok_q   <= tokens_i;
      raddr_q <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
      first_q <= 1'b1;
    end
    if (state_q == ST_SCAN) begin
      cidx_q <= raddr_q;
      if (raddr_q != IdxW'(SLOTS-1)) raddr_q <= raddr_q + 1'b1;
      // free slot search uses flip-flop valid bits directly
      if (!valid_q[raddr_q] && !free_q) begin
        free_q    <= 1'b1;
        freeidx_q <= raddr_q;
      end
    end
    if (scanning && !first_q) begin
      if (valid_q[cidx_q] && rtag == tag_q && !found_q) begin
        found_q <= 1'b1;
        fidx_q  <= cidx_q;
        fmet_q  <= rmet;
      end
      if (cidx_q == '0 || rmet < mmet_q) begin
        mmet_q <= rmet;
        midx_q <= cidx_q;
        mtag_q <= rtag;
      end
    end
    if (state_q == ST_SCAN) first_q <= 1'b0;
    if (state_q == ST_WRITE) begin
      hit_o         <= found_q;
      slot_index_o  <= 6'(found_q ? fidx_q : (kind_q ? '0 : target));
      evicted_o     <= !kind_q && !found_q && !free_q;
      evicted_tag_o <= (!kind_q && !found_q && !free_q) ? mtag_q : '0;
      status_o      <= kind_q && !found_q;
    end
  end
endmodule

### design/scr_ram.sv
// ----------------------------------------------------------------------------
// scr_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### design/scr_checker.sv
// ----------------------------------------------------------------------------
// scr_checker
// Port-level checks for the slot cache replacement core.
// ----------------------------------------------------------------------------
module scr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       hit_o,
  input logic       evicted_o,
  input logic [31:0] evicted_tag_o,
  input logic       status_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy not raised");
  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o)) else $error("done without busy");
  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && evicted_o |-> !hit_o && !status_o) else $error("evict on hit");
  a_etag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !evicted_o |-> evicted_tag_o == '0) else $error("stale tag");
endmodule

bind slot_cache_replacement_core scr_checker u_scr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
  .done_o(done_o), .hit_o(hit_o), .evicted_o(evicted_o),
  .evicted_tag_o(evicted_tag_o), .status_o(status_o)
);
